FILE: rtl/core/gtp_pkg.sv
package gtp_pkg;

    localparam int HISTORY_DEPTH_DEF = 4;

    localparam int TIME_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int WAIT_W   = 16;
    localparam int REQ_W    = 8;
    localparam int PRIO_W   = 24;
    localparam int RATE_W   = 24;
    localparam int RATE_FRAC = 16;
    localparam int RATE_ONE = 1 << RATE_FRAC;
    localparam int QUOT_W   = 24;
    localparam int STEP_W   = $clog2(QUOT_W + 1);

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
    localparam logic [REQ_W-1:0]  REQ_MAX  = {REQ_W{1'b1}};

    typedef logic [1:0] t_func;
    localparam t_func FUNC_RECORD = 2'd0;
    localparam t_func FUNC_TICK   = 2'd1;
    localparam t_func FUNC_QUERY  = 2'd2;

    typedef struct packed {
        logic rec;
        logic tick;
        logic q_init;
        logic rate_ld;
        logic rate_acc;
        logic num_calc;
        logic mul_calc;
        logic rq_zero;
        logic rq_sat;
        logic rq_div_ld;
        logic rq_take;
        logic prio_ld;
        logic prio_take;
    } t_cmd;

    typedef struct packed {
        logic any_zero;
        logic last_k;
        logic num_pos;
        logic rq_big;
        logic div_done;
    } t_sts;

endpackage

FILE: rtl/core/gtp_div.sv
module gtp_div import gtp_pkg::*; #(
    parameter int DIV_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    input  logic [STEP_W-1:0] i_steps,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_done
);

    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_dsh, n_dsh;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              ge;

    // divisor arrives pre-shifted to the top quotient bit
    assign ge = r_rem >= r_dsh;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_rem  = i_dividend;
            n_dsh  = i_divisor;
            n_quot = '0;
            n_cnt  = i_steps;
        end else if (r_cnt != '0) begin
            if (ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_quot = {r_quot[QUOT_W-2:0], ge};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;
    assign o_done = r_cnt == '0;

endmodule

FILE: rtl/core/gtp_datapath.sv
module gtp_datapath import gtp_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [TIME_W-1:0]  i_green_time,
    input  logic [COUNT_W-1:0] i_vehicle_count,
    output logic [REQ_W-1:0]   o_request_time,
    output logic [PRIO_W-1:0]  o_priority_res
);

    localparam int N      = HISTORY_DEPTH;
    localparam int CW     = $clog2(N);
    localparam int SUM_W  = RATE_W + CW;
    localparam int COEF_W = CW + 2;
    localparam int PROD_W = RATE_W + 1 + COEF_W;
    localparam int W_W    = 28 + 2 * CW;
    localparam int NUM_W  = 30 + 2 * CW;
    localparam int NUMT_W = NUM_W + TIME_W + 1;
    localparam int DEN_W  = 26 + 2 * CW;
    localparam int DIV_W  = NUMT_W + 2;

    localparam logic [CW:0]               N_L     = (CW + 1)'(N);
    localparam logic [CW-1:0]             K_LAST  = CW'(N - 1);
    localparam logic signed [NUM_W-1:0]   K_NM1   = NUM_W'(N - 1);
    localparam logic signed [NUM_W-1:0]   K_THREE = NUM_W'(3);
    localparam logic signed [NUM_W-1:0]   K_OFS   = NUM_W'(N * (N - 1) * RATE_ONE);
    localparam logic [DEN_W-1:0]          K_NN1   = DEN_W'(N * (N - 1));
    localparam logic [STEP_W-1:0]         RATE_STEPS = STEP_W'(QUOT_W);
    localparam logic [STEP_W-1:0]         REQ_STEPS  = STEP_W'(REQ_W);

    logic [TIME_W-1:0]  r_time  [N];
    logic [COUNT_W-1:0] r_count [N];
    logic [CW-1:0]      r_cursor;
    logic [WAIT_W-1:0]  r_wait;
    logic [REQ_W-1:0]   r_last_req;
    logic [PRIO_W-1:0]  r_last_prio;

    logic [CW-1:0]             r_k;
    logic [SUM_W-1:0]          r_sum_s;
    logic signed [W_W-1:0]     r_sum_w;
    logic [RATE_W-1:0]         r_yl;
    logic [TIME_W-1:0]         r_tlast;
    logic                      r_rsat;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [NUMT_W-1:0]  r_numt;
    logic [DEN_W-1:0]          r_den;
    logic [REQ_W-1:0]          r_req;

    logic [CW:0]               slot_sum;
    logic [CW-1:0]             slot;
    logic [TIME_W-1:0]         cur_time;
    logic [COUNT_W-1:0]        cur_count;
    logic                      rate_sat;
    logic [RATE_W-1:0]         y;
    logic signed [COEF_W-1:0]  coef;
    logic signed [PROD_W-1:0]  prod;
    logic signed [NUM_W-1:0]   num_next;
    logic [DIV_W-1:0]          d_val;
    logic [DIV_W-1:0]          e_val;
    logic [WAIT_W:0]           prio_sum;
    logic [REQ_W:0]            req_p1;
    logic                      any_zero;

    logic                      div_load;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIV_W-1:0]          div_divisor;
    logic [STEP_W-1:0]         div_steps;
    logic [QUOT_W-1:0]         div_q;
    logic                      div_done;

    // entry k of the ring, oldest first
    assign slot_sum  = {1'b0, r_cursor} + {1'b0, r_k};
    assign slot      = (slot_sum >= N_L) ? CW'(slot_sum - N_L) : CW'(slot_sum);
    assign cur_time  = r_time[slot];
    assign cur_count = r_count[slot];
    assign rate_sat  = cur_count >= {cur_time, 8'h00};

    assign y    = r_rsat ? RATE_MAX : div_q;
    assign coef = $signed(COEF_W'({r_k, 1'b1})) - $signed(COEF_W'(N));
    assign prod = $signed({1'b0, y}) * coef;

    assign num_next = $signed(NUM_W'(r_sum_s)) * K_NM1 + NUM_W'(r_sum_w) * K_THREE + K_OFS;

    // round half down: (2*num + den - 1) / (2*den)
    assign d_val = (DIV_W'($unsigned(r_numt)) << 1) + DIV_W'(r_den) - DIV_W'(1);
    assign e_val = DIV_W'(r_den) << 1;

    assign prio_sum = {1'b0, r_wait} + (WAIT_W + 1)'(r_req);
    assign req_p1   = {1'b0, r_req} + (REQ_W + 1)'(1);

    always_comb begin
        any_zero = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (r_time[i] == '0) begin
                any_zero = 1'b1;
            end
        end
    end

    always_comb begin
        div_load     = i_cmd.rate_ld | i_cmd.rq_div_ld | i_cmd.prio_ld;
        div_dividend = DIV_W'({cur_count, 16'h0000});
        div_divisor  = DIV_W'(cur_time) << (QUOT_W - 1);
        div_steps    = RATE_STEPS;
        if (i_cmd.rq_div_ld) begin
            div_dividend = d_val;
            div_divisor  = e_val << (REQ_W - 1);
            div_steps    = REQ_STEPS;
        end else if (i_cmd.prio_ld) begin
            div_dividend = DIV_W'({prio_sum, 8'h00});
            div_divisor  = DIV_W'(req_p1) << (QUOT_W - 1);
            div_steps    = RATE_STEPS;
        end
    end

    gtp_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_quot     (div_q),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_time[i]  <= '0;
                r_count[i] <= '0;
            end
            r_cursor    <= '0;
            r_wait      <= '0;
            r_last_req  <= '0;
            r_last_prio <= '0;
        end else begin
            if (i_cmd.rec) begin
                r_time[r_cursor]  <= i_green_time;
                r_count[r_cursor] <= i_vehicle_count;
                r_cursor          <= (r_cursor == K_LAST) ? '0 : r_cursor + CW'(1);
                r_wait            <= '0;
            end
            if (i_cmd.tick && r_wait != WAIT_MAX) begin
                r_wait <= r_wait + WAIT_W'(1);
            end
            if (i_cmd.prio_take) begin
                r_last_req  <= r_req;
                r_last_prio <= div_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_k     <= '0;
            r_sum_s <= '0;
            r_sum_w <= '0;
        end
        if (i_cmd.rate_ld) begin
            r_rsat <= rate_sat;
        end
        if (i_cmd.rate_acc) begin
            r_sum_s <= r_sum_s + SUM_W'(y);
            r_sum_w <= r_sum_w + W_W'(prod);
            r_yl    <= y;
            r_tlast <= cur_time;
            r_k     <= r_k + CW'(1);
        end
        if (i_cmd.num_calc) begin
            r_num <= num_next;
        end
        if (i_cmd.mul_calc) begin
            r_numt <= NUMT_W'(r_num) * $signed({1'b0, r_tlast});
            r_den  <= K_NN1 * (DEN_W'(r_yl) + DEN_W'(RATE_ONE));
        end
        if (i_cmd.rq_zero) begin
            r_req <= '0;
        end
        if (i_cmd.rq_sat) begin
            r_req <= REQ_MAX;
        end
        if (i_cmd.rq_take) begin
            r_req <= div_q[REQ_W-1:0];
        end
    end

    assign o_sts.any_zero = any_zero;
    assign o_sts.last_k   = r_k == K_LAST;
    assign o_sts.num_pos  = !r_num[NUM_W-1] && (r_num != '0);
    assign o_sts.rq_big   = d_val >= (e_val << REQ_W);
    assign o_sts.div_done = div_done;

    assign o_request_time = r_last_req;
    assign o_priority_res = r_last_prio;

endmodule

FILE: rtl/core/gtp_ctrl.sv
module gtp_ctrl import gtp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_func i_func,
    input  t_sts  i_sts,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_valid
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_ZCHK = 10'b00_0000_0010,
        S_RLD  = 10'b00_0000_0100,
        S_RATE = 10'b00_0000_1000,
        S_NUM  = 10'b00_0001_0000,
        S_MUL  = 10'b00_0010_0000,
        S_PREP = 10'b00_0100_0000,
        S_RQ   = 10'b00_1000_0000,
        S_PLD  = 10'b01_0000_0000,
        S_PRIO = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_func)
                        FUNC_RECORD: begin
                            o_cmd.rec = 1'b1;
                            n_valid   = 1'b1;
                        end
                        FUNC_TICK: begin
                            o_cmd.tick = 1'b1;
                            n_valid    = 1'b1;
                        end
                        FUNC_QUERY: begin
                            o_cmd.q_init = 1'b1;
                            n_state      = S_ZCHK;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ZCHK: begin
                if (i_sts.any_zero) begin
                    o_cmd.rq_zero = 1'b1;
                    n_state       = S_PLD;
                end else begin
                    n_state = S_RLD;
                end
            end
            S_RLD: begin
                o_cmd.rate_ld = 1'b1;
                n_state       = S_RATE;
            end
            S_RATE: begin
                if (i_sts.div_done) begin
                    o_cmd.rate_acc = 1'b1;
                    n_state        = i_sts.last_k ? S_NUM : S_RLD;
                end
            end
            S_NUM: begin
                o_cmd.num_calc = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                if (i_sts.num_pos) begin
                    o_cmd.mul_calc = 1'b1;
                    n_state        = S_PREP;
                end else begin
                    o_cmd.rq_zero = 1'b1;
                    n_state       = S_PLD;
                end
            end
            S_PREP: begin
                if (i_sts.rq_big) begin
                    o_cmd.rq_sat = 1'b1;
                    n_state      = S_PLD;
                end else begin
                    o_cmd.rq_div_ld = 1'b1;
                    n_state         = S_RQ;
                end
            end
            S_RQ: begin
                if (i_sts.div_done) begin
                    o_cmd.rq_take = 1'b1;
                    n_state       = S_PLD;
                end
            end
            S_PLD: begin
                o_cmd.prio_ld = 1'b1;
                n_state       = S_PRIO;
            end
            S_PRIO: begin
                if (i_sts.div_done) begin
                    o_cmd.prio_take = 1'b1;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_valid;

endmodule

FILE: rtl/core/green_time_predictor_core.sv
// Green-time predictor for one traffic direction. A request is taken when start is high
// and busy is low; every request yields one result, shown on o_request_time and
// o_priority_res for exactly one cycle while o_valid is high, and the receiver cannot
// stall it, so it must take the result in that cycle. Record, tick and unused codes
// leave busy low and their result follows on the next cycle, so they may be issued
// back to back. A query runs the line fit through one shared shift-subtract divider,
// 24 steps per stored rate plus 8 for the prediction and 24 for the priority, and
// keeps busy high until its result is shown; the 8 prediction steps are skipped when
// the prediction clamps at 255 or the fitted flow is not positive. A query with any
// empty or zero-time history slot skips the fit and the prediction. Results always
// carry the values of the latest query.
module green_time_predictor_core import gtp_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [TIME_W-1:0]  i_green_time,
    input  logic [COUNT_W-1:0] i_vehicle_count,
    output logic               o_valid,
    output logic [REQ_W-1:0]   o_request_time,
    output logic [PRIO_W-1:0]  o_priority_res
);

    t_cmd cmd;
    t_sts sts;
    logic ctrl_busy;

    gtp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (t_func'(i_func)),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy),
        .o_valid (o_valid)
    );

    gtp_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_green_time    (i_green_time),
        .i_vehicle_count (i_vehicle_count),
        .o_request_time  (o_request_time),
        .o_priority_res  (o_priority_res)
    );

    assign busy = ctrl_busy;

endmodule

FILE: dv/gtp_checker.sv
module gtp_checker import gtp_pkg::*; #(
    parameter int DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_func,
    input  logic [TIME_W-1:0]  i_green_time,
    input  logic [COUNT_W-1:0] i_vehicle_count,
    input  logic               o_valid,
    input  logic [REQ_W-1:0]   o_request_time,
    input  logic [PRIO_W-1:0]  o_priority_res,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [PRIO_W-1:0] prio;
    } t_answer;

    logic [TIME_W-1:0]  time_ring [DEPTH];
    logic [COUNT_W-1:0] count_ring [DEPTH];
    int unsigned        cursor;
    logic [WAIT_W-1:0]  waited;
    logic [REQ_W-1:0]   held_req;
    logic [PRIO_W-1:0]  held_prio;
    t_answer            answers_due [$];

    function automatic longint flow_of(longint cnt, longint tm);
        longint r;
        r = (cnt << 16) / tm;
        return (r > longint'(RATE_MAX)) ? longint'(RATE_MAX) : r;
    endfunction

    function automatic logic [REQ_W-1:0] green_forecast();
        longint sy, sw, yl, num, den, q, r;
        int unsigned s;
        sy = 0; sw = 0; yl = 0;
        for (int k = 0; k < DEPTH; k++) begin
            s = (cursor + k) % DEPTH;
            if (time_ring[s] == 0) return '0;
            yl = flow_of(count_ring[s], time_ring[s]);
            sy += yl;
            sw += (2 * (k + 1) - (DEPTH + 1)) * yl;
        end
        num = sy * (DEPTH - 1) + 3 * sw + DEPTH * (DEPTH - 1) * RATE_ONE;
        if (num <= 0) return '0;
        num *= time_ring[(cursor + DEPTH - 1) % DEPTH];
        den = DEPTH * (DEPTH - 1) * (yl + RATE_ONE);
        q = num / den;
        r = num - q * den;
        if (2 * r > den) q++;
        return (q > 255) ? REQ_MAX : q[REQ_W-1:0];
    endfunction

    assign pending_count = answers_due.size();

    always @(posedge i_clk) begin
        t_answer got, want;
        longint p;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                time_ring[k] = '0;
                count_ring[k] = '0;
            end
            cursor = 0;
            waited = '0;
            held_req = '0;
            held_prio = '0;
            fail_count <= 0;
            answers_due.delete();
        end else begin
            if (o_valid) begin
                got = '{o_request_time, o_priority_res};
                if (answers_due.size() == 0) begin
                    $error("result with no request waiting: req %0d prio %0h",
                           got.req, got.prio);
                    errs++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.req !== want.req) begin
                        $error("request_time expected %0d actual %0d", want.req, got.req);
                        errs++;
                    end
                    if (got.prio !== want.prio) begin
                        $error("priority_res expected %0h actual %0h", want.prio, got.prio);
                        errs++;
                    end
                end
            end
            if (start && !busy) begin
                case (i_func)
                    FUNC_RECORD: begin
                        time_ring[cursor] = i_green_time;
                        count_ring[cursor] = i_vehicle_count;
                        cursor = (cursor + 1) % DEPTH;
                        waited = '0;
                    end
                    FUNC_TICK: if (waited != WAIT_MAX) waited = waited + 1'b1;
                    FUNC_QUERY: begin
                        held_req = green_forecast();
                        p = ((longint'(waited) + held_req) << 8) / (held_req + 1);
                        held_prio = (p > 64'hFFFFFF) ? '1 : p[PRIO_W-1:0];
                    end
                    default: ;
                endcase
                answers_due.push_back('{held_req, held_prio});
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

FILE: dv/tb_green_time_predictor_core.sv
module tb_green_time_predictor_core import gtp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_func FUNC_NONE = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_func = FUNC_TICK;
    logic [TIME_W-1:0]  i_green_time = '0;
    logic [COUNT_W-1:0] i_vehicle_count = '0;
    logic               o_valid;
    logic [REQ_W-1:0]   o_request_time;
    logic [PRIO_W-1:0]  o_priority_res;
    int                 fail_count;
    int                 pending_count;
    bit                 quiet_tail = 0;

    always #2 i_clk = ~i_clk;

    green_time_predictor_core uut (.*);
    gtp_checker chk (.*);

    task automatic issue(input logic [1:0] f, input logic [7:0] t, input logic [15:0] c);
        logic free;
        i_func <= f;
        i_green_time <= t;
        i_vehicle_count <= c;
        start <= 1'b1;
        // busy only moves at rising edges, so the falling edge shows what the next edge sees
        do begin
            @(negedge i_clk);
            free = !busy;
            @(posedge i_clk);
        end while (!free);
        // accepted at this edge; maybe pause before next request
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic tick_burst(input int n);
        for (int k = 0; k < n; k++) issue(FUNC_TICK, 8'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [7:0]  t;
        logic [15:0] c;
        int roll;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty ring, extremes, overflow cases, unused code
        issue(FUNC_QUERY, 8'hFF, 16'hFFFF);
        issue(FUNC_NONE, 8'hAA, 16'h5555);
        issue(FUNC_RECORD, 8'd255, 16'hFFFF);
        issue(FUNC_RECORD, 8'd1, 16'hFFFF);
        issue(FUNC_RECORD, 8'd10, 16'd0);
        issue(FUNC_QUERY, 8'd0, 16'd0);
        issue(FUNC_RECORD, 8'd20, 16'd100);
        tick_burst(3);
        issue(FUNC_QUERY, 8'h55, 16'hAAAA);
        for (int k = 0; k < 4; k++) issue(FUNC_RECORD, 8'd255, 16'd0);
        issue(FUNC_QUERY, 8'd0, 16'd0);
        for (int k = 0; k < 4; k++) issue(FUNC_RECORD, 8'd1, 16'(1000 * (k + 1)));
        issue(FUNC_QUERY, 8'd0, 16'd0);
        issue(FUNC_RECORD, 8'd0, 16'd5);
        issue(FUNC_QUERY, 8'd0, 16'd0);
        // long wait with request 0
        tick_burst(40);
        issue(FUNC_QUERY, 8'd0, 16'd0);
        issue(FUNC_NONE, 8'd0, 16'd0);
        for (int n = 0; n < 1000; n++) begin
            if (n == 930) quiet_tail = 1;
            roll = $urandom_range(0, 99);
            t = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            c = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            if (roll < 40) issue(FUNC_RECORD, t, c);
            else if (roll < 70) tick_burst($urandom_range(1, 4));
            else if (roll < 95) issue(FUNC_QUERY, 8'($urandom), 16'($urandom));
            else issue(FUNC_NONE, 8'($urandom), 16'($urandom));
        end
        start <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/gtp_pkg.sv
rtl/core/gtp_div.sv
rtl/core/gtp_datapath.sv
rtl/core/gtp_ctrl.sv
rtl/core/green_time_predictor_core.sv
dv/gtp_checker.sv
dv/tb_green_time_predictor_core.sv
